[hw/rtl/nrtm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrtm_pkg
// shared constants and types of the nfa text matcher
// ----------------------------------------------------------------------------
package nrtm_pkg;

   localparam int NfaStates      = 32;
   localparam int RangesPerState = 4;
   localparam int StateIdxW      = 5;
   localparam int SlotW          = 2;
   localparam int CountW         = 3;

   typedef enum logic [1:0] {
      FUNC_RANGE = 2'd0,
      FUNC_ROW   = 2'd1,
      FUNC_BYTE  = 2'd2,
      FUNC_END   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CSR_START_SET  = 2'd0,
      CSR_ACCEPT     = 2'd1,
      CSR_MATCH_ALL  = 2'd2,
      CSR_NO_PATTERN = 2'd3
   } csr_index_type;

   // table write broadcast to every cell
   typedef struct packed {
      logic                 range_we;
      logic                 row_we;
      logic [StateIdxW-1:0] state_index;
      logic [SlotW-1:0]     range_slot;
      logic [7:0]           range_low;
      logic [8:0]           range_high;
      logic [31:0]          successor_mask;
      logic [CountW-1:0]    range_count;
      logic                 always_accepting;
   } table_wr_type;

endpackage

[hw/rtl/nrtm_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrtm_cell
// one nfa state: ranges, successor mask, accepting flag; ors its successor
// contribution into the chain
// ----------------------------------------------------------------------------
module nrtm_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [nrtm_pkg::StateIdxW-1:0] cell_index,
   input  nrtm_pkg::table_wr_type        wr,
   input  logic                          active,
   input  logic [7:0]                    text_byte,
   input  logic [nrtm_pkg::NfaStates-1:0] chain_in,
   output logic [nrtm_pkg::NfaStates-1:0] chain_out,
   output logic                          acc_hit
);
   import nrtm_pkg::*;

   logic [7:0]             lo_ff [RangesPerState];
   logic [8:0]             hi_ff [RangesPerState];
   logic [NfaStates-1:0]   succ_ff;
   logic [CountW-1:0]      cnt_ff, cnt_in;
   logic                   acc_ff;
   logic                   takes;

   always_ff @(posedge clock) begin
      if (wr.range_we && wr.state_index == cell_index) begin
         lo_ff[wr.range_slot] <= wr.range_low;
         hi_ff[wr.range_slot] <= (wr.range_high > 9'd256) ? 9'd256 : wr.range_high;
      end
      if (wr.row_we && wr.state_index == cell_index)
         succ_ff <= wr.successor_mask;
   end

   assign cnt_in = (wr.range_count > CountW'(RangesPerState)) ?
                   CountW'(RangesPerState) : wr.range_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         acc_ff <= 1'b0;
      end else if (wr.row_we && wr.state_index == cell_index) begin
         cnt_ff <= cnt_in;
         acc_ff <= wr.always_accepting;
      end
   end

   always_comb begin
      takes = 1'b0;
      for (int k = 0; k < RangesPerState; k++) begin
         if (CountW'(k) < cnt_ff && text_byte >= lo_ff[k] &&
             {1'b0, text_byte} < hi_ff[k])
            takes = 1'b1;
      end
   end

   assign acc_hit   = active & acc_ff;
   assign chain_out = chain_in | ((active && takes) ? succ_ff : '0);
endmodule

[hw/rtl/nfa_regex_text_matcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_regex_text_matcher
// bitset nfa over a byte stream, built as a row of state cells
// ----------------------------------------------------------------------------
// Table writes, text bytes and end of text are all accepted back to back while
// the result register is free. A byte is checked by all 32 state cells at
// once; their successor masks are or-ed along the cell row into the next
// active set. An end-of-text transaction loads the one-bit result register,
// which the input side may run past as soon as it is taken or was empty.
module nfa_regex_text_matcher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [4:0]  req_state_index,
   input  logic [1:0]  req_range_slot,
   input  logic [7:0]  req_range_low,
   input  logic [8:0]  req_range_high,
   input  logic [31:0] req_successor_mask,
   input  logic [2:0]  req_range_count,
   input  logic        req_always_accepting,
   input  logic [7:0]  req_text_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_matched,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import nrtm_pkg::*;

   logic [NfaStates-1:0] start_ff, active_ff, active_in;
   logic [4:0]           accept_ff;
   logic                 all_ff, nopat_ff;
   logic                 open_ff, open_in, win_ff, win_in;
   logic                 rsp_valid_ff, rsp_valid_in, rsp_matched_ff, rsp_matched_in;
   logic                 accepted, is_byte, is_end;
   table_wr_type         wr;
   logic [NfaStates-1:0] cur_set;
   logic [NfaStates-1:0] chain [NfaStates+1];
   logic [NfaStates-1:0] hits;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0; accept_ff <= '0; all_ff <= 1'b0; nopat_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_SET:  start_ff  <= csr_wdata;
            CSR_ACCEPT:     accept_ff <= csr_wdata[4:0];
            CSR_MATCH_ALL:  all_ff    <= csr_wdata[0];
            CSR_NO_PATTERN: nopat_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accepted  = req_valid && req_ready;
   assign is_byte   = accepted && func_type'(req_func) == FUNC_BYTE;
   assign is_end    = accepted && func_type'(req_func) == FUNC_END;

   always_comb begin
      wr.range_we         = accepted && func_type'(req_func) == FUNC_RANGE;
      wr.row_we           = accepted && func_type'(req_func) == FUNC_ROW;
      wr.state_index      = req_state_index;
      wr.range_slot       = req_range_slot;
      wr.range_low        = req_range_low;
      wr.range_high       = req_range_high;
      wr.successor_mask   = req_successor_mask;
      wr.range_count      = req_range_count;
      wr.always_accepting = req_always_accepting;
   end

   // a closed text starts from start_set
   assign cur_set  = open_ff ? active_ff : start_ff;
   assign chain[0] = '0;

   for (genvar s = 0; s < NfaStates; s++) begin : g_cell
      nrtm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (StateIdxW'(s)),
         .wr         (wr),
         .active     (cur_set[s]),
         .text_byte  (req_text_byte),
         .chain_in   (chain[s]),
         .chain_out  (chain[s+1]),
         .acc_hit    (hits[s])
      );
   end

   always_comb begin
      open_in   = open_ff;
      win_in    = open_ff ? win_ff : 1'b0;
      active_in = active_ff;
      if (is_byte) begin
         open_in = 1'b1;
         if (!win_in) begin
            if (|hits) win_in = 1'b1;
            else       active_in = chain[NfaStates];
         end else begin
            active_in = cur_set;
         end
      end else if (is_end) begin
         open_in = 1'b0; win_in = 1'b0; active_in = '0;
      end
   end

   always_comb begin
      if (all_ff)       rsp_matched_in = 1'b1;
      else if (nopat_ff) rsp_matched_in = !open_ff;
      else if (open_ff && win_ff) rsp_matched_in = 1'b1;
      else              rsp_matched_in = cur_set[accept_ff];
   end

   assign rsp_valid_in = is_end || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0; win_ff <= 1'b0; active_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         open_ff <= open_in; win_ff <= win_in; active_ff <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (is_end) rsp_matched_ff <= rsp_matched_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;

   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      is_end |=> !open_ff && !win_ff && active_ff == '0)
      else $error("end of text left text open");
   a_win_needs_open: assert property (@(posedge clock) disable iff (reset)
      win_ff |-> open_ff)
      else $error("early win without open text");
   a_rsp_from_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(is_end))
      else $error("result without end of text");
endmodule
